[design/mssc_pkg.sv]
package mssc_pkg;

   // Layout of the configuration tables, fixed by the register map.
   localparam int SLOT_COUNT = 6;
   localparam int POS_W      = 16;
   localparam int CUR_W      = 2;
   localparam int STOP_BIT   = 4;

   localparam logic [POS_W-1:0] RESET_POSITION  = 16'd4000;
   localparam logic [7:0]       INIT_TIMEOUT    = 8'd100;
   localparam logic [7:0]       RELEASE_TIMEOUT = 8'd50;
   localparam logic [7:0]       NO_SERVO        = 8'hFF;
   localparam logic [7:0]       HOLD_RESET      = 8'd50;
   localparam logic [15:0]      MANUAL_RESET    = 16'd500;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_SELECT,
      OP_POSITION,
      OP_INIT
   } mssc_op_type;

   typedef enum logic [3:0] {
      REG_POS_A,
      REG_POS_B,
      REG_SPEED,
      REG_INPUT_MAP,
      REG_ENABLE,
      REG_OFFSET,
      REG_HOLD,
      REG_MANUAL_HOLD
   } mssc_reg_type;

   typedef struct packed {
      logic [47:0] pos_a;
      logic [47:0] pos_b;
      logic [47:0] speed;
      logic [23:0] input_map;
      logic [5:0]  enable;
      logic [7:0]  offset;
      logic [7:0]  hold;
      logic [15:0] manual_hold;
   } mssc_cfg_type;

   // One servo's entry in the state memory.
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [CUR_W-1:0] current;
   } mssc_entry_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [4:0]       target;
      logic [7:0]       timeout;
      logic             active;
      logic             manual;
      logic             manual_moved;
      logic [7:0]       manual_pos;
      logic [7:0]       pos_a;
      logic [7:0]       pos_b;
      logic [7:0]       speed;
      logic [7:0]       offset;
      logic [7:0]       hold;
   } mssc_step_in_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [4:0]       target;
      logic [7:0]       timeout;
      logic             written;
      logic             slewed;
      logic             arrived;
      logic             restart;
   } mssc_step_out_type;

   function automatic logic [7:0] field8(input logic [47:0] tbl, input logic [2:0] k);
      return tbl[{k, 3'b000} +: 8];
   endfunction

   function automatic logic [3:0] field4(input logic [23:0] tbl, input logic [2:0] k);
      return tbl[{k, 2'b00} +: 4];
   endfunction

   // (p + offset) * 32, at most 14 bits.
   function automatic logic [13:0] scaled(input logic [7:0] p, input logic [7:0] off);
      logic [8:0] sum;
      sum = {1'b0, p} + {1'b0, off};
      return {sum, 5'b00000};
   endfunction

   // End position for end state 1 (A), 2 (B), or the middle of both otherwise.
   function automatic logic [13:0] config_pos(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] off, input logic [1:0] st);
      logic [13:0] a32;
      logic [13:0] b32;
      a32 = scaled(a, off);
      b32 = scaled(b, off);
      case (st)
         2'd1:    return a32;
         2'd2:    return b32;
         default: return 14'({1'b0, a32[13:1]} + {1'b0, b32[13:1]});
      endcase
   endfunction

   // Real input pair m-1, m for a nonzero map entry m.
   function automatic logic [1:0] mapped_pair(input logic [3:0] m, input logic [15:0] ins);
      logic [3:0] sh;
      sh = m - 4'd1;
      if (m == 4'd0) begin
         return 2'b00;
      end
      return 2'(ins >> sh);
   endfunction

endpackage

[design/mssc_if.sv]
interface mssc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [11:0] request_bits;
   logic [15:0] input_bits;
   logic [7:0]  value;

   modport source (output valid, op, request_bits, input_bits, value, input ready);
   modport sink (input valid, op, request_bits, input_bits, value, output ready);
endinterface

interface mssc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  servo_index;
   logic [13:0] compare_value;
   logic        compare_written;
   logic        signal_active;
   logic [11:0] virtual_inputs;
   logic [5:0]  running_mask;

   modport source (output valid, servo_index, compare_value, compare_written, signal_active,
                   virtual_inputs, running_mask, input ready);
   modport sink (input valid, servo_index, compare_value, compare_written, signal_active,
                 virtual_inputs, running_mask, output ready);
endinterface

interface mssc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/mssc_ram.sv]
module mssc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 6
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Registered read; a read of the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mssc_csr.sv]
module mssc_csr
   import mssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mssc_csr_if.sink     csr_ch,
   output mssc_cfg_type cfg
);

   localparam mssc_cfg_type CFG_RESET = '{
      pos_a:       '0,
      pos_b:       '0,
      speed:       '0,
      input_map:   '0,
      enable:      '0,
      offset:      '0,
      hold:        HOLD_RESET,
      manual_hold: MANUAL_RESET
   };

   mssc_cfg_type cfg_ff;

   // Writes are taken on every cycle outside reset.
   assign csr_ch.ready = !reset;

   // Register writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_ch.valid) begin
         case (mssc_reg_type'(csr_ch.index))
            REG_POS_A:       cfg_ff.pos_a       <= csr_ch.data;
            REG_POS_B:       cfg_ff.pos_b       <= csr_ch.data;
            REG_SPEED:       cfg_ff.speed       <= csr_ch.data;
            REG_INPUT_MAP:   cfg_ff.input_map   <= csr_ch.data[23:0];
            REG_ENABLE:      cfg_ff.enable      <= csr_ch.data[5:0];
            REG_OFFSET:      cfg_ff.offset      <= csr_ch.data[7:0];
            REG_HOLD:        cfg_ff.hold        <= csr_ch.data[7:0];
            REG_MANUAL_HOLD: cfg_ff.manual_hold <= csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/mssc_step.sv]
module mssc_step
   import mssc_pkg::*;
(
   input  mssc_step_in_type  step_in,
   output mssc_step_out_type step_out
);

   logic [13:0]      goal;
   logic [4:0]       tgt;
   logic [7:0]       tmo;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] goal16;
   logic [POS_W-1:0] gap;
   logic             above;
   logic             below;

   // Timeout countdown and slew of the serviced servo toward its end position.
   always_comb begin
      goal     = step_in.manual ? scaled(step_in.manual_pos, step_in.offset)
                                : config_pos(step_in.pos_a, step_in.pos_b, step_in.offset,
                                             step_in.target[1:0]);
      goal16   = {2'b00, goal};
      above    = step_in.position > goal16;
      below    = step_in.position < goal16;
      gap      = above ? (step_in.position - goal16) : (goal16 - step_in.position);
      tgt      = step_in.target;
      tmo      = step_in.timeout;
      pos      = step_in.position;
      step_out = '0;

      if (step_in.active) begin
         // A new manual position wakes the signal and restarts manual mode.
         if (step_in.manual && step_in.manual_moved) begin
            tgt[STOP_BIT]    = 1'b0;
            tmo              = '0;
            step_out.restart = 1'b1;
         end
         if (tmo != 8'd0) begin
            tmo = tmo - 8'd1;
            if (tmo == 8'd0) begin
               tgt[STOP_BIT] = 1'b1;
            end
         end
         // The stop bit is judged as it stood before this tick's changes.
         if (!step_in.target[STOP_BIT] && tmo == 8'd0) begin
            step_out.written = 1'b1;
            step_out.slewed  = 1'b1;
            if (gap < {8'd0, step_in.speed}) begin
               pos              = goal16;
               tmo              = step_in.hold;
               step_out.arrived = 1'b1;
            end else if (above) begin
               pos = step_in.position - {8'd0, step_in.speed};
            end else if (below) begin
               pos = step_in.position + {8'd0, step_in.speed};
            end
         end
      end else begin
         tgt[STOP_BIT] = 1'b1;
      end

      step_out.target   = tgt;
      step_out.timeout  = tmo;
      step_out.position = pos;
   end

endmodule

[design/multi_servo_slew_controller_core.sv]
// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    op, request_bits, input_bits, value
// rsp_ch    out  valid/ready    servo_index, compare_value, compare_written,
//                               signal_active, virtual_inputs, running_mask
// csr_ch    in   valid/ready    index, data (ready is high outside reset)
//
// An accepted item enters the update stage along with the read of its servo's entry;
// when that stage fires, its result loads the output register and can then leave.
// One item per cycle is sustained while results are not stalled. The state memory read
// is registered, with a write-back forward covering back-to-back access to the same servo.
// Synchronous reset; no clearing pass, the memory is covered by valid bits.
// A stalled result holds the update stage, which then holds the input.
module multi_servo_slew_controller_core
   import mssc_pkg::*;
#(
   parameter int SERVO_COUNT = 6
) (
   input  logic      clock,
   input  logic      reset,
   mssc_req_if.sink  req_ch,
   mssc_rsp_if.source rsp_ch,
   mssc_csr_if.sink  csr_ch
);

   localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

   mssc_cfg_type      cfg;
   mssc_step_in_type  step_in;
   mssc_step_out_type step_out;

   // Pipeline and service control.
   logic [IDX_W-1:0] counter_ff;
   logic [IDX_W-1:0] next_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             in_ok;
   logic             accept;
   logic             s1_valid_ff;
   mssc_op_type      s1_op_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             s1_ok_ff;
   logic [11:0]      s1_req_ff;
   logic [15:0]      s1_ins_ff;
   logic [7:0]       s1_val_ff;
   logic             s1_has_rsp;
   logic             s1_fire;
   logic             fwd_hit_ff;
   mssc_entry_type   fwd_data_ff;
   logic             fwd_hit_in;

   // Per-servo state held in flops.
   logic [4:0]             tgt_ff [SERVO_COUNT];
   logic [4:0]             tgt_in [SERVO_COUNT];
   logic [7:0]             pt_ff [SERVO_COUNT];
   logic [7:0]             pt_in [SERVO_COUNT];
   logic [4:0]             rel_t [SERVO_COUNT];
   logic [7:0]             rel_p [SERVO_COUNT];
   logic [SERVO_COUNT-1:0] moving_ff;
   logic [SERVO_COUNT-1:0] moving_in;
   logic [SERVO_COUNT-1:0] active_ff;
   logic [SERVO_COUNT-1:0] active_in;
   logic [SERVO_COUNT-1:0] valid_ff;
   logic [11:0]            reported_ff;
   logic [11:0]            reported_in;

   // Manual positioning state.
   logic [7:0]  ms_ff;
   logic [7:0]  ms_in;
   logic [7:0]  msl_ff;
   logic [7:0]  msl_in;
   logic [7:0]  mp_ff;
   logic [7:0]  mp_in;
   logic [7:0]  mpl_ff;
   logic [7:0]  mpl_in;
   logic [15:0] mt_ff;
   logic [15:0] mt_in;
   logic        manual_chg;
   logic [15:0] mt_load;
   logic        manual_end;
   logic [15:0] mt_dec;
   logic [7:0]  ms_after;

   // Memory access and update results.
   mssc_entry_type ram_q;
   mssc_entry_type entry;
   mssc_entry_type reset_entry;
   mssc_entry_type ram_wdata;
   logic           ram_we;
   logic [1:0]     req_pair;
   logic           req_hit;
   logic [1:0]     seen;
   logic [3:0]     map_s;
   logic [1:0]     init_st;
   logic           written;
   logic [POS_W-1:0] rsp_pos;

   // Output register.
   logic        rsp_valid_ff;
   logic [2:0]  rsp_idx_ff;
   logic [13:0] rsp_cmp_ff;
   logic        rsp_wr_ff;
   logic        rsp_act_ff;
   logic [11:0] rsp_virt_ff;
   logic [5:0]  rsp_run_ff;

   mssc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   mssc_ram #(
      .WIDTH ($bits(mssc_entry_type)),
      .DEPTH (SERVO_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_fire && ram_we),
      .wr_addr (s1_idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   mssc_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   // Input side: pick the servo whose entry is read.
   assign next_idx   = (counter_ff == IDX_W'(SERVO_COUNT - 1)) ? '0 : counter_ff + 1'b1;
   assign in_ok      = req_ch.value < 8'(SERVO_COUNT);
   assign rd_addr    = (mssc_op_type'(req_ch.op) == OP_TICK) ? next_idx
                     : (in_ok ? IDX_W'(req_ch.value) : '0);
   assign s1_has_rsp = (s1_op_ff == OP_TICK) || (s1_op_ff == OP_INIT && s1_ok_ff);
   assign s1_fire    = s1_valid_ff && (!s1_has_rsp || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!s1_valid_ff || s1_fire);
   assign accept     = req_ch.valid && req_ch.ready;
   assign fwd_hit_in = s1_fire && ram_we && (s1_idx_ff == rd_addr);

   // Entry of the serviced servo: forwarded write, memory word, or reset value.
   always_comb begin
      reset_entry          = '0;
      reset_entry.position = (s1_idx_ff == '0) ? RESET_POSITION : '0;
      if (fwd_hit_ff) begin
         entry = fwd_data_ff;
      end else if (valid_ff[s1_idx_ff]) begin
         entry = ram_q;
      end else begin
         entry = reset_entry;
      end
   end

   // Manual mode bookkeeping for a tick.
   assign manual_chg = msl_ff != ms_ff;
   assign mt_load    = manual_chg ? cfg.manual_hold : mt_ff;
   assign manual_end = mt_load == 16'd1;
   assign mt_dec     = (mt_load == 16'd0) ? 16'd0 : mt_load - 16'd1;
   assign ms_after   = manual_end ? NO_SERVO : ms_ff;

   assign req_pair = 2'(s1_req_ff >> {s1_idx_ff, 1'b0});
   assign req_hit  = (req_pair == 2'd1 || req_pair == 2'd2)
                  && (tgt_ff[s1_idx_ff][1:0] != req_pair);

   // New request for the serviced servo, then releases of the manual servos.
   always_comb begin
      for (int k = 0; k < SERVO_COUNT; k++) begin
         rel_t[k] = tgt_ff[k];
         rel_p[k] = pt_ff[k];
         if (IDX_W'(k) == s1_idx_ff && req_hit) begin
            rel_t[k] = {3'b000, req_pair};
            rel_p[k] = '0;
         end
         if (manual_chg && msl_ff == 8'(k)) begin
            rel_t[k][STOP_BIT] = 1'b0;
            rel_p[k]           = '0;
         end
         if (manual_chg && ms_ff == 8'(k)) begin
            rel_t[k][STOP_BIT] = 1'b0;
            rel_p[k]           = '0;
         end
         if (manual_end && ms_ff == 8'(k)) begin
            rel_t[k][STOP_BIT] = 1'b0;
            rel_p[k]           = RELEASE_TIMEOUT;
         end
      end
   end

   always_comb begin
      step_in              = '0;
      step_in.position     = entry.position;
      step_in.target       = rel_t[s1_idx_ff];
      step_in.timeout      = rel_p[s1_idx_ff];
      step_in.active       = active_ff[s1_idx_ff];
      step_in.manual       = ms_after == 8'(s1_idx_ff);
      step_in.manual_moved = mp_ff != mpl_ff;
      step_in.manual_pos   = mp_ff;
      step_in.pos_a        = field8(cfg.pos_a, 3'(s1_idx_ff));
      step_in.pos_b        = field8(cfg.pos_b, 3'(s1_idx_ff));
      step_in.speed        = field8(cfg.speed, 3'(s1_idx_ff));
      step_in.offset       = cfg.offset;
      step_in.hold         = cfg.hold;
   end

   assign map_s   = field4(cfg.input_map, 3'(s1_idx_ff));
   assign init_st = mapped_pair(map_s, s1_ins_ff);
   assign seen    = (map_s != 4'd0) ? init_st
                  : (moving_ff[s1_idx_ff] ? 2'b00 : entry.current);

   // Next state of everything the item in the update stage touches.
   always_comb begin
      tgt_in      = tgt_ff;
      pt_in       = pt_ff;
      moving_in   = moving_ff;
      active_in   = active_ff;
      reported_in = reported_ff;
      ms_in       = ms_ff;
      msl_in      = msl_ff;
      mp_in       = mp_ff;
      mpl_in      = mpl_ff;
      mt_in       = mt_ff;
      ram_we      = 1'b0;
      ram_wdata   = entry;
      written     = 1'b0;
      case (s1_op_ff)
         OP_SELECT: begin
            ms_in = s1_val_ff;
         end
         OP_POSITION: begin
            mp_in = s1_val_ff;
         end
         OP_INIT: begin
            if (s1_ok_ff) begin
               if (cfg.enable[s1_idx_ff]) begin
                  tgt_in[s1_idx_ff]    = {3'b000, init_st};
                  pt_in[s1_idx_ff]     = INIT_TIMEOUT;
                  active_in[s1_idx_ff] = 1'b1;
                  ram_we               = 1'b1;
                  ram_wdata.current    = init_st;
                  ram_wdata.position   = {2'b00, config_pos(step_in.pos_a, step_in.pos_b,
                                                            cfg.offset, init_st)};
                  written              = 1'b1;
               end else begin
                  tgt_in[s1_idx_ff][STOP_BIT] = 1'b1;
               end
            end
         end
         OP_TICK: begin
            tgt_in            = rel_t;
            pt_in             = rel_p;
            tgt_in[s1_idx_ff] = step_out.target;
            pt_in[s1_idx_ff]  = step_out.timeout;
            for (int k = 0; k < SERVO_COUNT; k++) begin
               if (IDX_W'(k) == s1_idx_ff) begin
                  reported_in[2*k +: 2] = seen;
               end
            end
            if (manual_chg) begin
               msl_in = ms_ff;
            end
            ms_in = ms_after;
            mt_in = step_out.restart ? cfg.manual_hold : mt_dec;
            if (step_out.restart) begin
               mpl_in = mp_ff;
            end
            if (step_out.slewed) begin
               moving_in[s1_idx_ff] = !step_out.arrived;
            end
            ram_we             = 1'b1;
            ram_wdata.position = step_out.position;
            ram_wdata.current  = step_out.arrived ? step_out.target[1:0] : entry.current;
            written            = step_out.written;
         end
         default: ;
      endcase
   end

   assign rsp_pos = ram_we ? ram_wdata.position : entry.position;

   // Input transfer into the update stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         counter_ff  <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= fwd_hit_in;
            if (mssc_op_type'(req_ch.op) == OP_TICK) begin
               counter_ff <= next_idx;
            end
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= mssc_op_type'(req_ch.op);
         s1_idx_ff   <= rd_addr;
         s1_ok_ff    <= in_ok;
         s1_req_ff   <= req_ch.request_bits;
         s1_ins_ff   <= req_ch.input_bits;
         s1_val_ff   <= req_ch.value;
         fwd_data_ff <= ram_wdata;
      end
   end

   // State update at the end of the update stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SERVO_COUNT; k++) begin
            tgt_ff[k] <= '0;
            pt_ff[k]  <= '0;
         end
         moving_ff   <= '0;
         active_ff   <= '0;
         valid_ff    <= '0;
         reported_ff <= '0;
         ms_ff       <= NO_SERVO;
         msl_ff      <= NO_SERVO;
         mp_ff       <= '0;
         mpl_ff      <= '0;
         mt_ff       <= '0;
      end else if (s1_fire) begin
         tgt_ff      <= tgt_in;
         pt_ff       <= pt_in;
         moving_ff   <= moving_in;
         active_ff   <= active_in;
         reported_ff <= reported_in;
         ms_ff       <= ms_in;
         msl_ff      <= msl_in;
         mp_ff       <= mp_in;
         mpl_ff      <= mpl_in;
         mt_ff       <= mt_in;
         if (ram_we) begin
            valid_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   // Output register; a new result loads as the previous one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_has_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_has_rsp) begin
         rsp_idx_ff  <= 3'(s1_idx_ff);
         rsp_cmp_ff  <= rsp_pos[POS_W-1:2];
         rsp_wr_ff   <= written;
         rsp_act_ff  <= !tgt_in[s1_idx_ff][STOP_BIT];
         rsp_virt_ff <= reported_in;
         rsp_run_ff  <= 6'(moving_in);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.servo_index     = rsp_idx_ff;
   assign rsp_ch.compare_value   = rsp_cmp_ff;
   assign rsp_ch.compare_written = rsp_wr_ff;
   assign rsp_ch.signal_active   = rsp_act_ff;
   assign rsp_ch.virtual_inputs  = rsp_virt_ff;
   assign rsp_ch.running_mask    = rsp_run_ff;

endmodule

[bench/tb_multi_servo_slew_controller_core.sv]
`timescale 1ns / 1ps

module tb_multi_servo_slew_controller_core;
   import mssc_pkg::*;

   localparam int SERVO_N = 6;

   typedef enum int {
      PHASE_RANDOM,
      PHASE_ALL_ONES,
      PHASE_ALL_ZEROS
   } phase_kind_type;

   // One expected or observed result transfer.
   typedef struct packed {
      logic [2:0]  servo;
      logic [13:0] compare;
      logic        written;
      logic        active;
      logic [11:0] inputs;
      logic [5:0]  running;
   } servo_report_type;

   logic clock = 1'b0;
   logic reset;

   mssc_req_if req_ch();
   mssc_rsp_if rsp_ch();
   mssc_csr_if csr_ch();

   multi_servo_slew_controller_core #(
      .SERVO_COUNT(SERVO_N)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #4 clock = ~clock;

   // Shadow copy of the configuration and the per-servo state.
   mssc_cfg_type shadow_cfg;
   logic [15:0] shadow_position [SERVO_N];
   logic [4:0]  shadow_target [SERVO_N];
   logic [4:0]  shadow_current [SERVO_N];
   logic [7:0]  shadow_timeout [SERVO_N];
   logic [5:0]  shadow_moving;
   logic [5:0]  shadow_active;
   logic [11:0] shadow_reported;
   int          shadow_counter;
   logic [7:0]  shadow_manual_select;
   logic [7:0]  shadow_manual_select_last;
   logic [7:0]  shadow_manual_pos;
   logic [7:0]  shadow_manual_pos_last;
   logic [15:0] shadow_manual_timeout;

   servo_report_type expected_reports [$];
   int error_count = 0;
   int mismatch_count = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   function automatic void reset_shadow();
      shadow_cfg = '0;
      shadow_cfg.hold = HOLD_RESET;
      shadow_cfg.manual_hold = MANUAL_RESET;
      for (int k = 0; k < SERVO_N; k++) begin
         shadow_position[k] = '0;
         shadow_target[k] = '0;
         shadow_current[k] = '0;
         shadow_timeout[k] = '0;
      end
      shadow_position[0] = RESET_POSITION;
      shadow_moving = '0;
      shadow_active = '0;
      shadow_reported = '0;
      shadow_counter = 0;
      shadow_manual_select = NO_SERVO;
      shadow_manual_select_last = NO_SERVO;
      shadow_manual_pos = '0;
      shadow_manual_pos_last = '0;
      shadow_manual_timeout = '0;
   endfunction

   // An 8-bit position plus the offset, scaled by 32.
   function automatic logic [15:0] scale_pos(input logic [7:0] p);
      logic [15:0] sum;
      sum = 16'(p) + 16'(shadow_cfg.offset);
      return sum << 5;
   endfunction

   // End position A, B, or the middle of both for any other state.
   function automatic logic [15:0] end_pos(input int k, input logic [1:0] st);
      logic [15:0] a32;
      logic [15:0] b32;
      a32 = scale_pos(shadow_cfg.pos_a[8*k +: 8]);
      b32 = scale_pos(shadow_cfg.pos_b[8*k +: 8]);
      case (st)
         2'd1:    return a32;
         2'd2:    return b32;
         default: return (a32 >> 1) + (b32 >> 1);
      endcase
   endfunction

   // Pair of real inputs that a servo's map entry points at.
   function automatic logic [1:0] pair_of(input int k, input logic [15:0] ins);
      logic [3:0]  m;
      logic [15:0] sh;
      m = shadow_cfg.input_map[4*k +: 4];
      if (m == 4'd0) begin
         return 2'b00;
      end
      sh = ins >> (m - 4'd1);
      return sh[1:0];
   endfunction

   // Lets the pulse of a servo run again, if the index names one.
   function automatic void release_servo(input logic [7:0] k, input logic [7:0] tmo);
      if (k < SERVO_N) begin
         shadow_target[k][STOP_BIT] = 1'b0;
         shadow_timeout[k] = tmo;
      end
   endfunction

   // Applies one accepted item to the shadow state and queues its result.
   function automatic void predict_servo_update(input mssc_op_type op, input logic [11:0] req,
                                                input logic [15:0] ins, input logic [7:0] val);
      int               s;
      logic             written;
      logic [1:0]       r;
      logic [1:0]       v;
      logic [1:0]       pr;
      logic [4:0]       st;
      logic [15:0]      end_p;
      logic [7:0]       spd;
      int               diff;
      int               abs_diff;
      servo_report_type rep;
      written = 1'b0;
      case (op)
         OP_SELECT: begin
            shadow_manual_select = val;
            return;
         end
         OP_POSITION: begin
            shadow_manual_pos = val;
            return;
         end
         OP_INIT: begin
            if (val >= SERVO_N) begin
               return;
            end
            s = int'(val);
            if (shadow_cfg.enable[s]) begin
               pr = pair_of(s, ins);
               shadow_target[s] = {3'b000, pr};
               shadow_current[s] = {3'b000, pr};
               shadow_position[s] = end_pos(s, pr);
               shadow_timeout[s] = INIT_TIMEOUT;
               shadow_active[s] = 1'b1;
               written = 1'b1;
            end else begin
               shadow_target[s][STOP_BIT] = 1'b1;
               shadow_current[s][STOP_BIT] = 1'b1;
            end
         end
         default: begin
            s = shadow_counter + 1;
            if (s >= SERVO_N) begin
               s = 0;
            end
            shadow_counter = s;

            // A single request bit selects a new end position.
            r = req[2*s +: 2];
            if ((r == 2'd1 || r == 2'd2) && shadow_target[s][1:0] != r) begin
               shadow_target[s] = {3'b000, r};
               shadow_timeout[s] = '0;
            end

            // Real inputs where mapped, else the settled end position.
            if (shadow_cfg.input_map[4*s +: 4] != 4'd0) begin
               v = pair_of(s, ins);
            end else begin
               v = shadow_moving[s] ? 2'b00 : shadow_current[s][1:0];
            end
            shadow_reported[2*s +: 2] = v;

            // Manual positioning bookkeeping.
            if (shadow_manual_select_last != shadow_manual_select) begin
               release_servo(shadow_manual_select_last, 8'd0);
               shadow_manual_timeout = shadow_cfg.manual_hold;
               release_servo(shadow_manual_select, 8'd0);
               shadow_manual_select_last = shadow_manual_select;
            end
            if (shadow_manual_timeout > 0) begin
               shadow_manual_timeout--;
               if (shadow_manual_timeout == 0) begin
                  release_servo(shadow_manual_select, RELEASE_TIMEOUT);
                  shadow_manual_select = NO_SERVO;
               end
            end

            if (shadow_active[s]) begin
               st = shadow_target[s];
               if (shadow_manual_select == 8'(s)) begin
                  end_p = scale_pos(shadow_manual_pos);
                  if (shadow_manual_pos != shadow_manual_pos_last) begin
                     shadow_manual_pos_last = shadow_manual_pos;
                     shadow_target[s][STOP_BIT] = 1'b0;
                     shadow_timeout[s] = '0;
                     shadow_manual_timeout = shadow_cfg.manual_hold;
                  end
               end else begin
                  end_p = end_pos(s, st[1:0]);
               end
               if (shadow_timeout[s] > 0) begin
                  shadow_timeout[s]--;
                  if (shadow_timeout[s] == 0) begin
                     shadow_target[s][STOP_BIT] = 1'b1;
                  end
               end
               // Slew toward the end position, or land on it when within one step.
               if (!st[STOP_BIT] && shadow_timeout[s] == 0) begin
                  spd = shadow_cfg.speed[8*s +: 8];
                  diff = int'(shadow_position[s]) - int'(end_p);
                  abs_diff = (diff < 0) ? -diff : diff;
                  if (abs_diff < int'(spd)) begin
                     shadow_position[s] = end_p;
                     shadow_timeout[s] = shadow_cfg.hold;
                     shadow_moving[s] = 1'b0;
                     shadow_current[s] = shadow_target[s];
                  end else begin
                     if (diff > 0) begin
                        shadow_position[s] = shadow_position[s] - 16'(spd);
                     end
                     if (diff < 0) begin
                        shadow_position[s] = shadow_position[s] + 16'(spd);
                     end
                     shadow_moving[s] = 1'b1;
                  end
                  written = 1'b1;
               end
            end else begin
               shadow_target[s][STOP_BIT] = 1'b1;
            end
         end
      endcase
      rep.servo = 3'(s);
      rep.compare = shadow_position[s][15:2];
      rep.written = written;
      rep.active = !shadow_target[s][STOP_BIT];
      rep.inputs = shadow_reported;
      rep.running = shadow_moving;
      expected_reports.push_back(rep);
   endfunction

   // Every accepted request transfer updates the shadow state.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_servo_update(mssc_op_type'(req_ch.op), req_ch.request_bits,
                              req_ch.input_bits, req_ch.value);
      end
   end

   // Each result transfer is checked against the oldest expected report.
   servo_report_type got_report;
   servo_report_type want_report;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_report = '{rsp_ch.servo_index, rsp_ch.compare_value, rsp_ch.compare_written,
                        rsp_ch.signal_active, rsp_ch.virtual_inputs, rsp_ch.running_mask};
         if (expected_reports.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: servo %0d compare %0d", got_report.servo,
                        got_report.compare);
            end
         end else begin
            want_report = expected_reports.pop_front();
            if (got_report.servo !== want_report.servo ||
                got_report.compare !== want_report.compare ||
                got_report.written !== want_report.written ||
                got_report.active !== want_report.active ||
                got_report.inputs !== want_report.inputs ||
                got_report.running !== want_report.running) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected servo %0d cmp %0d wr %0b act %0b vin %h run %b",
                           want_report.servo, want_report.compare, want_report.written,
                           want_report.active, want_report.inputs, want_report.running);
                  $display("          actual   servo %0d cmp %0d wr %0b act %0b vin %h run %b",
                           got_report.servo, got_report.compare, got_report.written,
                           got_report.active, got_report.inputs, got_report.running);
               end
            end
         end
      end
   end

   // The result side draws a stall before each transfer when idling is on.
   initial begin : drive_rsp_ready
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Sends one request item, after a random gap when idling is on, and waits for its transfer.
   task automatic send_item(input mssc_op_type op, input logic [11:0] req,
                            input logic [15:0] ins, input logic [7:0] val);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.request_bits <= req;
      req_ch.input_bits <= ins;
      req_ch.value <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Holds off requests until every expected result has come, then lets
   // items that cause no result clear the pipeline.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input mssc_reg_type idx, input logic [47:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         REG_POS_A:       shadow_cfg.pos_a = data;
         REG_POS_B:       shadow_cfg.pos_b = data;
         REG_SPEED:       shadow_cfg.speed = data;
         REG_INPUT_MAP:   shadow_cfg.input_map = data[23:0];
         REG_ENABLE:      shadow_cfg.enable = data[5:0];
         REG_OFFSET:      shadow_cfg.offset = data[7:0];
         REG_HOLD:        shadow_cfg.hold = data[7:0];
         REG_MANUAL_HOLD: shadow_cfg.manual_hold = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [47:0] pos_a, input logic [47:0] pos_b,
                                 input logic [47:0] speed, input logic [23:0] input_map,
                                 input logic [5:0] enable, input logic [7:0] offset,
                                 input logic [7:0] hold, input logic [15:0] manual_hold);
      write_reg(REG_POS_A, pos_a);
      write_reg(REG_POS_B, pos_b);
      write_reg(REG_SPEED, speed);
      write_reg(REG_INPUT_MAP, 48'(input_map));
      write_reg(REG_ENABLE, 48'(enable));
      write_reg(REG_OFFSET, 48'(offset));
      write_reg(REG_HOLD, 48'(hold));
      write_reg(REG_MANUAL_HOLD, 48'(manual_hold));
   endtask

   // Ticks and a disabled initialisation with the registers as reset left them.
   task automatic check_reset_state();
      send_item(OP_TICK, 12'h000, 16'h0000, 8'd0);
      send_item(OP_TICK, 12'hFFF, 16'hFFFF, 8'd255);
      send_item(OP_INIT, 12'h000, 16'h0000, 8'd0);
   endtask

   // Every operation, field extremes, ignored indices, a disabled servo,
   // a servo with zero speed, and manual mode running out by itself.
   task automatic check_directed_cases();
      drain_pipeline();
      apply_settings(48'h10_FF_30_00_C0_FF, 48'h00_20_FF_FF_10_00, 48'h05_00_FF_40_01_20,
                     24'h0_3_2_F_1_0, 6'b011111, 8'd16, 8'd2, 16'd3);
      send_item(OP_INIT, 12'h000, 16'h0000, 8'd0);
      send_item(OP_INIT, 12'hFFF, 16'h0001, 8'd1);
      send_item(OP_INIT, 12'h000, 16'hC000, 8'd2);
      send_item(OP_INIT, 12'h000, 16'h0004, 8'd3);
      send_item(OP_INIT, 12'h000, 16'hFFFF, 8'd4);
      send_item(OP_INIT, 12'h000, 16'hFFFF, 8'd5);
      send_item(OP_INIT, 12'h000, 16'hFFFF, 8'd6);
      send_item(OP_INIT, 12'h000, 16'hFFFF, 8'd255);
      send_item(OP_TICK, 12'hFFF, 16'hFFFF, 8'd0);
      send_item(OP_TICK, 12'h555, 16'h0000, 8'd0);
      send_item(OP_TICK, 12'hAAA, 16'h5555, 8'd0);
      send_item(OP_SELECT, 12'h000, 16'h0000, 8'd2);
      send_item(OP_TICK, 12'h000, 16'hAAAA, 8'd0);
      send_item(OP_POSITION, 12'h000, 16'h0000, 8'd255);
      send_item(OP_TICK, 12'h000, 16'h0000, 8'd0);
      send_item(OP_TICK, 12'h000, 16'h0000, 8'd0);
      send_item(OP_SELECT, 12'h000, 16'h0000, 8'd200);
      send_item(OP_TICK, 12'h000, 16'h0000, 8'd0);
      send_item(OP_POSITION, 12'h000, 16'h0000, 8'd0);
   endtask

   // One setting of the registers, every servo initialised, then a random
   // mix dominated by ticks with request bits that change only now and then.
   task automatic run_random_phase(input phase_kind_type kind, input int n_items);
      logic [47:0] pos_a;
      logic [47:0] pos_b;
      logic [47:0] speed;
      logic [23:0] input_map;
      logic [5:0]  enable;
      logic [7:0]  offset;
      logic [7:0]  hold;
      logic [15:0] manual_hold;
      logic [11:0] held_req;
      logic [7:0]  val;
      int          roll;
      int          k;
      drain_pipeline();
      case (kind)
         PHASE_ALL_ONES: begin
            pos_a = '1;
            pos_b = '1;
            speed = '1;
            input_map = '1;
            enable = '1;
            offset = '1;
            hold = '1;
            manual_hold = '1;
         end
         PHASE_ALL_ZEROS: begin
            pos_a = '0;
            pos_b = '0;
            speed = '0;
            input_map = '0;
            enable = '0;
            offset = '0;
            hold = '0;
            manual_hold = '0;
         end
         default: begin
            pos_a = 48'({$urandom, $urandom});
            pos_b = 48'({$urandom, $urandom});
            for (int b = 0; b < SERVO_N; b++) begin
               speed[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            end
            input_map = 24'($urandom);
            enable = 6'($urandom | $urandom);
            offset = 8'($urandom);
            hold = 8'($urandom_range(0, 12));
            manual_hold = 16'($urandom_range(0, 40));
         end
      endcase
      apply_settings(pos_a, pos_b, speed, input_map, enable, offset, hold, manual_hold);

      for (int j = 0; j < SERVO_N; j++) begin
         send_item(OP_INIT, 12'($urandom), 16'($urandom), 8'(j));
      end

      held_req = 12'($urandom);
      for (int i = 0; i < n_items; i++) begin
         // Stretches with and without idling on either side.
         if (i % 64 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, SERVO_N - 1);
            held_req[2*k +: 2] = 2'($urandom);
         end
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            send_item(OP_TICK, held_req, 16'($urandom), 8'($urandom));
         end else if (roll < 80) begin
            val = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, SERVO_N - 1))
                                             : 8'($urandom);
            send_item(OP_SELECT, 12'($urandom), 16'($urandom), val);
         end else if (roll < 90) begin
            send_item(OP_POSITION, 12'($urandom), 16'($urandom), 8'($urandom));
         end else if (roll < 98) begin
            send_item(OP_INIT, 12'($urandom), 16'($urandom),
                      8'($urandom_range(0, SERVO_N - 1)));
         end else begin
            send_item(OP_INIT, 12'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   // Test sequence and final verdict.
   initial begin : run_tests
      int wait_cycles;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_TICK;
      req_ch.request_bits = '0;
      req_ch.input_bits = '0;
      req_ch.value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_POS_A;
      csr_ch.data = '0;
      reset_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_reset_state();
      check_directed_cases();
      run_random_phase(PHASE_RANDOM, 290);
      run_random_phase(PHASE_ALL_ONES, 290);
      run_random_phase(PHASE_RANDOM, 290);
      run_random_phase(PHASE_ALL_ZEROS, 290);
      run_random_phase(PHASE_RANDOM, 290);
      run_random_phase(PHASE_RANDOM, 290);

      // Wait for the last results, bounded, then let the pipeline settle.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait_cycles = 0;
      while (expected_reports.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_reports.size() != 0) begin
         error_count += expected_reports.size();
         $display("%0d expected results never arrived", expected_reports.size());
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
design/mssc_pkg.sv
design/mssc_if.sv
design/mssc_ram.sv
design/mssc_csr.sv
design/mssc_step.sv
design/multi_servo_slew_controller_core.sv
bench/tb_multi_servo_slew_controller_core.sv
